// ===== hdl/hcfa_pkg.sv =====
// Shared constants, types and ring-pointer helpers for the frame assembler.
package hcfa_pkg;

    localparam int FRAME_BYTES  = 300;
    localparam int BUFFER_DEPTH = 512;
    localparam int HDR_LEN      = 4;
    localparam int TYPE_POS     = 4;

    localparam int PTR_W  = $clog2(BUFFER_DEPTH);
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam int SIDX_W = $clog2(FRAME_BYTES);
    localparam int CNT_W  = $clog2(FRAME_BYTES + 1);

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int TIME_W  = 32;
    localparam int RIDX_W  = 9;
    localparam int EVENT_W = 3;
    localparam int LEVEL_W = 10;
    localparam int TMO_W   = 16;

    localparam int APB_DW    = 32;
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [PTR_W-1:0]     t_ptr;
    typedef logic [FILL_W-1:0]    t_fill;
    typedef logic [SIDX_W-1:0]    t_sidx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_TIMEOUT = t_reg_idx'(0);
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd1000;

    localparam t_byte HDR_B0 = 8'h55;
    localparam t_byte HDR_B1 = 8'hAA;
    localparam t_byte HDR_B2 = 8'hEB;
    localparam t_byte HDR_B3 = 8'h90;
    localparam logic [4*BYTE_W-1:0] HEADER = {HDR_B0, HDR_B1, HDR_B2, HDR_B3};
    localparam t_byte HEADER_SUM = HDR_B0 + HDR_B1 + HDR_B2 + HDR_B3;

    typedef enum logic [CMD_W-1:0] {
        CMD_DATA  = 2'd0,
        CMD_CHUNK = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_FRAME_OK = 3'd1,
        EV_CSUM_ERR = 3'd2,
        EV_TIMEOUT  = 3'd3,
        EV_READ     = 3'd4
    } t_event;

    typedef struct packed {
        logic  we;
        t_ptr  waddr;
        t_byte wdata;
        logic  re;
        t_ptr  raddr;
    } t_ring_req;

    typedef struct packed {
        logic  we;
        t_sidx waddr;
        t_byte wdata;
        logic  re;
        t_sidx raddr;
    } t_store_req;

    function automatic t_ptr ring_add(t_ptr a, t_fill b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(BUFFER_DEPTH)) begin
            s = s - SUM_W'(BUFFER_DEPTH);
        end
        return PTR_W'(s);
    endfunction

    function automatic t_ptr ring_sub(t_ptr a, t_fill b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(BUFFER_DEPTH) - SUM_W'(b);
        if (s >= SUM_W'(BUFFER_DEPTH)) begin
            s = s - SUM_W'(BUFFER_DEPTH);
        end
        return PTR_W'(s);
    endfunction

    function automatic t_ptr ring_inc(t_ptr a);
        return ring_add(a, FILL_W'(1));
    endfunction

endpackage

// ===== hdl/hcfa_if.sv =====
// Request channel interfaces for the frame assembler input and result streams.
interface hcfa_in_if import hcfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;
    logic [TIME_W-1:0] now_ms;
    logic [RIDX_W-1:0] read_index;

    modport source (output valid, command, data_byte, now_ms, read_index, input ready);
    modport sink   (input valid, command, data_byte, now_ms, read_index, output ready);
endinterface

interface hcfa_out_if import hcfa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  frame_type;
    logic [BYTE_W-1:0]  read_data;
    logic [LEVEL_W-1:0] fill_level;

    modport source (output valid, event_res, frame_type, read_data, fill_level, input ready);
    modport sink   (input valid, event_res, frame_type, read_data, fill_level, output ready);
endinterface

// ===== hdl/hcfa_apb_regs.sv =====
// APB register block holding the chunk timeout.
module hcfa_apb_regs import hcfa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    output logic [TMO_W-1:0]   o_timeout_ms
);

    logic [TMO_W-1:0] r_timeout_ms;
    t_reg_idx         reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_timeout_ms = r_timeout_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms <= TIMEOUT_RESET;
        end else if (wr_en && (reg_idx == REG_TIMEOUT)) begin
            r_timeout_ms <= pwdata[TMO_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TIMEOUT: prdata = APB_DW'(r_timeout_ms);
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== hdl/hcfa_ring_buffer.sv =====
// Receive ring memory: one write port, one registered read port.
module hcfa_ring_buffer import hcfa_pkg::*; (
    input  logic      i_clk,
    input  t_ring_req i_req,
    output t_byte     o_rdata
);

    t_byte r_mem [BUFFER_DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/hcfa_frame_store.sv =====
// Last good frame memory: copy write port, registered read port.
module hcfa_frame_store import hcfa_pkg::*; (
    input  logic       i_clk,
    input  t_store_req i_req,
    output t_byte      o_rdata
);

    t_byte r_mem [FRAME_BYTES];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/hcfa_core.sv =====
// Frame sequencer: append, header sync, checksum, rescan and copy sweeps, chunk timeout and stored-frame reads.
module hcfa_core import hcfa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [TMO_W-1:0] i_timeout_ms,
    hcfa_in_if.sink          i_in,
    hcfa_out_if.source       o_out,
    output t_ring_req        o_ring_req,
    input  t_byte            i_ring_rdata,
    output t_store_req       o_store_req,
    input  t_byte            i_store_rdata
);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_COPY, S_READ, S_OUT} t_state;

    t_state               r_state;
    t_ptr                 r_start;
    t_fill                r_fill;
    logic [TIME_W-1:0]    r_last;
    logic                 r_stored;
    t_byte                r_sum;
    logic [2:0][BYTE_W-1:0] r_win;
    t_ptr                 r_rptr;
    t_cnt                 r_icnt;
    t_cnt                 r_dcnt;
    t_cnt                 r_nreads;
    logic                 r_rd_v;
    logic                 r_rd_last;
    logic                 r_found;
    t_fill                r_hfill;
    t_byte                r_type;
    logic                 r_rd_ok;
    t_event               r_ev;
    t_byte                r_ftype;
    t_byte                r_rdata;
    logic                 r_o_valid;
    t_event               r_o_ev;
    t_byte                r_o_type;
    t_byte                r_o_rdata;
    logic [LEVEL_W-1:0]   r_o_level;

    logic              in_acc;
    t_cmd              cmd;
    logic              full;
    t_ptr              base_start;
    t_fill             base_fill;
    t_ptr              wr_addr;
    t_fill             fill_inc;
    logic              new_hdr;
    logic [TIME_W-1:0] gap;
    logic              idx_ok;
    logic              issue;
    logic              scan_hit;
    t_fill             n_hfill;
    t_byte             n_sum;
    t_fill             scan_fill;

    always_comb begin
        in_acc     = i_in.valid && (r_state == S_IDLE);
        cmd        = t_cmd'(i_in.command);
        full       = (r_fill == FILL_W'(BUFFER_DEPTH));
        base_start = full ? '0 : r_start;
        base_fill  = full ? '0 : r_fill;
        wr_addr    = ring_add(base_start, base_fill);
        fill_inc   = base_fill + FILL_W'(1);
        new_hdr    = ({r_win, i_in.data_byte} == HEADER);
        gap        = i_in.now_ms - r_last;
        idx_ok     = (32'(i_in.read_index) < 32'(FRAME_BYTES));
        issue      = ((r_state == S_SCAN) || (r_state == S_COPY)) && (r_icnt != r_nreads);
        scan_hit   = ({r_win, i_ring_rdata} == HEADER) && (r_dcnt >= CNT_W'(HDR_LEN - 1));
        n_hfill    = r_found ? (r_hfill + FILL_W'(1)) : FILL_W'(HDR_LEN);
        n_sum      = r_found ? (r_sum + i_ring_rdata) : HEADER_SUM;
        scan_fill  = (r_found || scan_hit) ? n_hfill : FILL_W'(HDR_LEN - 1);
    end

    always_comb begin
        o_ring_req.we    = in_acc && (cmd == CMD_DATA);
        o_ring_req.waddr = wr_addr;
        o_ring_req.wdata = i_in.data_byte;
        o_ring_req.re    = issue;
        o_ring_req.raddr = r_rptr;

        o_store_req.we    = (r_state == S_COPY) && r_rd_v;
        o_store_req.waddr = SIDX_W'(r_dcnt);
        o_store_req.wdata = i_ring_rdata;
        o_store_req.re    = in_acc && (cmd == CMD_READ) && idx_ok;
        o_store_req.raddr = SIDX_W'(i_in.read_index);
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_o_valid;
    assign o_out.event_res  = r_o_ev;
    assign o_out.frame_type = r_o_type;
    assign o_out.read_data  = r_o_rdata;
    assign o_out.fill_level = r_o_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= '0;
            r_fill    <= '0;
            r_last    <= '0;
            r_stored  <= 1'b0;
            r_rd_v    <= 1'b0;
            r_rd_last <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && o_out.ready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            r_rd_v    <= issue;
            r_rd_last <= issue && (r_icnt == (r_nreads - CNT_W'(1)));
            if (issue) begin
                r_rptr <= ring_inc(r_rptr);
                r_icnt <= r_icnt + CNT_W'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ftype <= '0;
                        r_rdata <= '0;
                        unique case (cmd)
                            CMD_DATA: begin
                                r_ev    <= EV_NONE;
                                r_win   <= {r_win[1:0], i_in.data_byte};
                                r_start <= ((fill_inc == FILL_W'(HDR_LEN)) && !new_hdr) ?
                                           ring_inc(base_start) : base_start;
                                if (32'(fill_inc) == 32'(FRAME_BYTES)) begin
                                    r_fill <= fill_inc;
                                    r_icnt <= '0;
                                    r_dcnt <= '0;
                                    if (r_sum == i_in.data_byte) begin
                                        r_rptr   <= base_start;
                                        r_nreads <= CNT_W'(FRAME_BYTES);
                                        r_state  <= S_COPY;
                                    end else begin
                                        r_rptr   <= ring_inc(base_start);
                                        r_nreads <= CNT_W'(FRAME_BYTES - 1);
                                        r_found  <= 1'b0;
                                        r_state  <= S_SCAN;
                                    end
                                end else begin
                                    r_state <= S_OUT;
                                    if (fill_inc < FILL_W'(HDR_LEN)) begin
                                        r_fill <= fill_inc;
                                    end else if (fill_inc == FILL_W'(HDR_LEN)) begin
                                        if (new_hdr) begin
                                            r_fill <= fill_inc;
                                            r_sum  <= HEADER_SUM;
                                        end else begin
                                            r_fill <= fill_inc - FILL_W'(1);
                                        end
                                    end else begin
                                        r_fill <= fill_inc;
                                        r_sum  <= r_sum + i_in.data_byte;
                                    end
                                end
                            end
                            CMD_CHUNK: begin
                                r_last  <= i_in.now_ms;
                                r_state <= S_OUT;
                                if ((r_fill != '0) && (gap > TIME_W'(i_timeout_ms))) begin
                                    r_fill  <= '0;
                                    r_start <= '0;
                                    r_ev    <= EV_TIMEOUT;
                                end else begin
                                    r_ev    <= EV_NONE;
                                end
                            end
                            CMD_READ: begin
                                r_ev    <= EV_READ;
                                r_rd_ok <= r_stored && idx_ok;
                                r_state <= S_READ;
                            end
                            default: begin
                                r_ev    <= EV_NONE;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_rd_v) begin
                        r_win  <= {r_win[1:0], i_ring_rdata};
                        r_dcnt <= r_dcnt + CNT_W'(1);
                        if (r_found || scan_hit) begin
                            r_found <= 1'b1;
                            r_hfill <= n_hfill;
                            r_sum   <= n_sum;
                        end
                        if (r_rd_last) begin
                            r_fill  <= scan_fill;
                            r_start <= ring_sub(r_rptr, scan_fill);
                            r_ev    <= EV_CSUM_ERR;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_COPY: begin
                    if (r_rd_v) begin
                        r_dcnt <= r_dcnt + CNT_W'(1);
                        if (r_dcnt == CNT_W'(TYPE_POS)) begin
                            r_type <= i_ring_rdata;
                        end
                        if (r_rd_last) begin
                            r_stored <= 1'b1;
                            r_start  <= r_rptr;
                            r_fill   <= '0;
                            r_ev     <= EV_FRAME_OK;
                            r_ftype  <= r_type;
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_READ: begin
                    r_rdata <= r_rd_ok ? i_store_rdata : '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_valid <= 1'b1;
                        r_o_ev    <= r_ev;
                        r_o_type  <= r_ftype;
                        r_o_rdata <= r_rdata;
                        r_o_level <= LEVEL_W'(r_fill);
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/header_checksum_frame_assembler_unit.sv =====
// Top level of the header and checksum frame assembler.
//
//  channel   dir  fields                                       handshake
//  i_in      in   command, data_byte, now_ms, read_index        valid/ready
//  o_out     out  event_res, frame_type, read_data, fill_level  valid/ready
//  apb       in   timeout_ms at byte address 0                  psel/penable
//
// One request at a time. The byte that completes a frame runs a sweep over the
// receive ring read port: a copy on a good checksum, a rescan on a bad one.
// Reset clears pointers and flags only; memories are not cleared.
// A finished result sits in the output register, so the next request is taken
// while it waits; a second result stalls until the first is taken.
module header_checksum_frame_assembler_unit import hcfa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hcfa_in_if.sink            i_in,
    hcfa_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic [TMO_W-1:0] timeout_ms;
    t_ring_req        ring_req;
    t_byte            ring_rdata;
    t_store_req       store_req;
    t_byte            store_rdata;

    hcfa_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_timeout_ms (timeout_ms)
    );

    hcfa_ring_buffer u_ring (
        .i_clk   (i_clk),
        .i_req   (ring_req),
        .o_rdata (ring_rdata)
    );

    hcfa_frame_store u_store (
        .i_clk   (i_clk),
        .i_req   (store_req),
        .o_rdata (store_rdata)
    );

    hcfa_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_timeout_ms  (timeout_ms),
        .i_in          (i_in),
        .o_out         (o_out),
        .o_ring_req    (ring_req),
        .i_ring_rdata  (ring_rdata),
        .o_store_req   (store_req),
        .i_store_rdata (store_rdata)
    );

endmodule

// ===== bench/tb_header_checksum_frame_assembler_unit.sv =====
// Testbench for the frame assembler: request streams checked against a cycle-free predictor.
module tb_header_checksum_frame_assembler_unit;
    import hcfa_pkg::*;

    localparam logic [CMD_W-1:0]   CMD_UNUSED   = 2'd3;
    localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
    localparam int                 IDLE_LIMIT   = 4000;
    localparam int                 PHASES       = 3;

    typedef struct packed {
        t_event             ev;
        t_byte              ftype;
        t_byte              rdata;
        logic [LEVEL_W-1:0] level;
    } t_outcome;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG, STALL_TOGGLE} t_stall;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [APB_DW-1:0]  pwdata  = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    hcfa_in_if  in_ch ();
    hcfa_out_if out_ch ();

    header_checksum_frame_assembler_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    t_byte             rx_ring [BUFFER_DEPTH];
    int                rx_head       = 0;
    int                rx_count      = 0;
    logic [TIME_W-1:0] last_chunk_ms = '0;
    t_byte             good_copy [FRAME_BYTES];
    bit                have_frame    = 1'b0;
    logic [TMO_W-1:0]  timeout_cfg   = TIMEOUT_RESET;

    t_outcome          pending_outcomes [$];
    t_outcome          oldest_outcome;
    int                mismatches    = 0;
    int                requests_sent = 0;
    int                burst_left    = 0;
    logic [TIME_W-1:0] ms_clock      = '0;
    t_byte             frame_img [FRAME_BYTES];
    t_stall            stall_mode    = STALL_NONE;
    int                stall_left    = 0;

    function automatic t_byte rx_at(int i);
        return rx_ring[(rx_head + i) % BUFFER_DEPTH];
    endfunction

    function automatic bit hdr_at(int pos);
        return {rx_at(pos), rx_at(pos + 1), rx_at(pos + 2), rx_at(pos + 3)} == HEADER;
    endfunction

    function automatic void rx_drop(int n);
        if (n > rx_count) begin
            n = rx_count;
        end
        rx_head  = (rx_head + n) % BUFFER_DEPTH;
        rx_count = rx_count - n;
    endfunction

    function automatic t_outcome frame_outcome(logic [CMD_W-1:0] cmd, t_byte data,
                                               logic [TIME_W-1:0] now,
                                               logic [RIDX_W-1:0] idx);
        t_outcome          res;
        logic [TIME_W-1:0] gap;
        t_byte             sum;
        int                h;
        int                i;
        bit                scanning;
        res.ev    = EV_NONE;
        res.ftype = '0;
        res.rdata = '0;
        case (cmd)
            CMD_DATA: begin
                if (rx_count >= BUFFER_DEPTH) begin
                    rx_count = 0;
                    rx_head  = 0;
                end
                rx_ring[(rx_head + rx_count) % BUFFER_DEPTH] = data;
                rx_count++;
                scanning = 1'b1;
                while (scanning && rx_count > 0) begin
                    h = 0;
                    while (h + HDR_LEN <= rx_count && !hdr_at(h)) begin
                        h++;
                    end
                    rx_drop(h);
                    // with a full frame buffered the header always sits at the front
                    if (rx_count < FRAME_BYTES) begin
                        scanning = 1'b0;
                    end else begin
                        sum = '0;
                        for (i = 0; i < FRAME_BYTES - 1; i++) begin
                            sum = sum + rx_at(i);
                        end
                        if (sum != rx_at(FRAME_BYTES - 1)) begin
                            res.ev    = EV_CSUM_ERR;
                            res.ftype = '0;
                            rx_drop(1);
                        end else begin
                            for (i = 0; i < FRAME_BYTES; i++) begin
                                good_copy[i] = rx_at(i);
                            end
                            have_frame = 1'b1;
                            res.ev     = EV_FRAME_OK;
                            res.ftype  = good_copy[TYPE_POS];
                            rx_drop(FRAME_BYTES);
                        end
                    end
                end
            end
            CMD_CHUNK: begin
                gap = now - last_chunk_ms;
                if (rx_count > 0 && gap > TIME_W'(timeout_cfg)) begin
                    rx_count = 0;
                    rx_head  = 0;
                    res.ev   = EV_TIMEOUT;
                end
                last_chunk_ms = now;
            end
            CMD_READ: begin
                res.ev = EV_READ;
                if (have_frame && idx < FRAME_BYTES) begin
                    res.rdata = good_copy[idx];
                end
            end
            default: begin
            end
        endcase
        res.level = LEVEL_W'(rx_count);
        return res;
    endfunction

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic send_req(logic [CMD_W-1:0] cmd, t_byte data, logic [TIME_W-1:0] now,
                            logic [RIDX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.data_byte  <= data;
        in_ch.now_ms     <= now;
        in_ch.read_index <= idx;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_outcomes.push_back(frame_outcome(cmd, data, now, idx));
        requests_sent++;
    endtask

    task automatic send_byte(t_byte b);
        send_req(CMD_DATA, b, TIME_W'($urandom), RIDX_W'($urandom));
    endtask

    task automatic send_chunk(logic [TIME_W-1:0] gap);
        ms_clock = ms_clock + gap;
        send_req(CMD_CHUNK, t_byte'($urandom), ms_clock, RIDX_W'($urandom));
    endtask

    task automatic send_read(logic [RIDX_W-1:0] idx);
        send_req(CMD_READ, t_byte'($urandom), TIME_W'($urandom), idx);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [TMO_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= {(APB_DW - TMO_W)'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        timeout_cfg = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_expect(logic [TMO_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TIMEOUT_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("timeout_ms", 32'(value), 32'(prdata[TMO_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] intime_gap();
        return TIME_W'($urandom_range(0, timeout_cfg));
    endfunction

    function automatic logic [TIME_W-1:0] late_gap();
        logic [TIME_W-1:0] extra;
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'hFFFE_0000)
                                            : $urandom_range(0, 5000);
        return TIME_W'(timeout_cfg) + 1 + extra;
    endfunction

    function automatic logic [RIDX_W-1:0] random_index();
        if ($urandom_range(0, 4) == 0) begin
            return RIDX_W'($urandom_range(FRAME_BYTES, 2 ** RIDX_W - 1));
        end
        return RIDX_W'($urandom_range(0, FRAME_BYTES - 1));
    endfunction

    function automatic void build_frame(bit corrupt, bit embed_hdr);
        t_byte sum;
        int    pos;
        int    i;
        for (i = 0; i < FRAME_BYTES - 1; i++) begin
            frame_img[i] = (i < HDR_LEN) ? HEADER[8 * (3 - i) +: 8] : t_byte'($urandom);
        end
        if (embed_hdr) begin
            pos = $urandom_range(TYPE_POS + 1, FRAME_BYTES - 1 - HDR_LEN);
            for (i = 0; i < HDR_LEN; i++) begin
                frame_img[pos + i] = HEADER[8 * (3 - i) +: 8];
            end
        end
        sum = '0;
        for (i = 0; i < FRAME_BYTES - 1; i++) begin
            sum = sum + frame_img[i];
        end
        frame_img[FRAME_BYTES - 1] = corrupt ? sum + t_byte'($urandom_range(1, 255)) : sum;
    endfunction

    // chunk starts and reads may fall between frame bytes
    task automatic send_frame(int count, bit interleave);
        int i;
        int r;
        for (i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (interleave && r < 2) begin
                send_chunk(intime_gap());
            end else if (interleave && r < 3) begin
                send_read(random_index());
            end
            send_byte(frame_img[i]);
        end
    endtask

    task automatic test_register_reset();
        cfg_expect(TIMEOUT_RESET);
    endtask

    task automatic test_directed_corners();
        send_read('0);
        send_read('1);
        send_req(CMD_UNUSED, 8'hFF, '1, '1);
        send_chunk(32'hFFFF_FFFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR_B0);
        send_byte(HDR_B1);
        send_chunk(TIME_W'(TIMEOUT_RESET));
        send_chunk(TIME_W'(TIMEOUT_RESET) + 1);
        send_read(RIDX_W'(FRAME_BYTES - 1));
        send_read(RIDX_W'(FRAME_BYTES));
        send_req(CMD_UNUSED, 8'h00, '0, '0);
    endtask

    task automatic test_timeout_extremes();
        drain_results();
        cfg_write('0);
        cfg_expect('0);
        send_byte(HDR_B0);
        send_chunk(0);
        send_chunk(1);
        drain_results();
        cfg_write('1);
        cfg_expect('1);
        send_byte(HDR_B2);
        send_chunk(32'h0000_FFFF);
        send_chunk(32'h0001_0000);
    endtask

    // a stray header in front of a good frame fails the checksum, then the rescan
    // lands on the real header and the frame completes
    task automatic test_frame_store();
        int k;
        int i;
        build_frame(1'b0, $urandom_range(0, 1));
        k = $urandom_range(1, 8);
        for (i = 0; i < HDR_LEN; i++) begin
            send_byte(HEADER[8 * (3 - i) +: 8]);
        end
        repeat (k) send_byte(t_byte'($urandom));
        send_frame(FRAME_BYTES, 1'b1);
        send_read('0);
        send_read(RIDX_W'(TYPE_POS));
        send_read(RIDX_W'(FRAME_BYTES - 1));
        send_read(RIDX_W'(FRAME_BYTES));
    endtask

    task automatic test_random_traffic();
        logic [TMO_W-1:0] setting;
        int               phase;
        int               phase_start;
        int               pick;
        int               n;
        int               k;
        for (phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0:       setting = '1;
                1:       setting = '0;
                default: setting = TMO_W'($urandom_range(1, 3000));
            endcase
            cfg_write(setting);
            cfg_expect(setting);
            phase_start = requests_sent;
            while (requests_sent - phase_start < 25) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    // partial frame dropped by a late chunk start
                    build_frame(1'b0, 1'b0);
                    send_frame($urandom_range(HDR_LEN, 12), 1'b1);
                    send_chunk(late_gap());
                end else if (pick < 60) begin
                    n = $urandom_range(1, 12);
                    repeat (n) begin
                        k = $urandom_range(0, 7);
                        send_byte(k < HDR_LEN ? HEADER[8 * (3 - k) +: 8] : t_byte'($urandom));
                    end
                end else if (pick < 80) begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_read(random_index());
                end else if (pick < 95) begin
                    send_chunk(($urandom_range(0, 1) == 0) ? intime_gap() : late_gap());
                end else begin
                    send_req(CMD_UNUSED, t_byte'($urandom), TIME_W'($urandom),
                             RIDX_W'($urandom));
                end
            end
        end
    endtask

    // result sink stall pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall'($urandom_range(0, 3));
            stall_left <= $urandom_range(4, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:   out_ch.ready <= 1'b1;
            STALL_RANDOM: out_ch.ready <= ($urandom_range(0, 9) < 6);
            STALL_LONG:   out_ch.ready <= (stall_left < 2);
            default:      out_ch.ready <= ~out_ch.ready;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual event_res %0d",
                         $time, out_ch.event_res);
                mismatches++;
            end else begin
                oldest_outcome = pending_outcomes.pop_front();
                check_field("event_res", 32'(oldest_outcome.ev), 32'(out_ch.event_res));
                check_field("frame_type", 32'(oldest_outcome.ftype), 32'(out_ch.frame_type));
                check_field("read_data", 32'(oldest_outcome.rdata), 32'(out_ch.read_data));
                check_field("fill_level", 32'(oldest_outcome.level), 32'(out_ch.fill_level));
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.command    = CMD_DATA;
        in_ch.data_byte  = '0;
        in_ch.now_ms     = '0;
        in_ch.read_index = '0;
        out_ch.ready     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_directed_corners();
        test_timeout_extremes();
        test_frame_store();
        test_random_traffic();
        drain_results();
        repeat (FRAME_BYTES + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/hcfa_pkg.sv
hdl/hcfa_if.sv
hdl/hcfa_apb_regs.sv
hdl/hcfa_ring_buffer.sv
hdl/hcfa_frame_store.sv
hdl/hcfa_core.sv
hdl/header_checksum_frame_assembler_unit.sv
bench/tb_header_checksum_frame_assembler_unit.sv
